/* design/pagp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package pagp_pkg;

  // port width, bits at or above it are unmapped
  localparam int BITS_PER_PORT = 32;
  localparam int BIT_W = 5;
  localparam int IDX_W = BIT_W + 1;
  localparam int CFG_DEPTH = 2 ** IDX_W;
  localparam logic [31:0] PORT_MASK = (BITS_PER_PORT >= 32) ? 32'hFFFF_FFFF :
                                      32'((64'd1 << BITS_PER_PORT) - 64'd1);

  // operation codes
  typedef enum logic [2:0] {
    MODE_MUX   = 3'd0,
    MODE_DIR   = 3'd1,
    MODE_WRITE = 3'd2,
    MODE_READ  = 3'd3,
    MODE_DRIVE = 3'd4,
    MODE_PULL  = 3'd5
  } mode_t;

  // value codes
  localparam logic [3:0] MUX_DISABLE = 4'd15;
  localparam logic [3:0] MUX_FN_MAX  = 4'd7;
  localparam logic [3:0] DIR_IN      = 4'd0;
  localparam logic [3:0] DIR_OUT     = 4'd1;
  localparam logic [3:0] WR_LOW      = 4'd0;
  localparam logic [3:0] WR_HIGH     = 4'd1;
  localparam logic [3:0] WR_TOGGLE   = 4'd2;
  localparam logic [3:0] FLAG_MAX    = 4'd1;

  // port select codes
  localparam logic PORT_A = 1'b0;
  localparam logic PORT_B = 1'b1;

  // per-pin configuration bit positions
  localparam int CFG_MUXEN  = 0;
  localparam int CFG_INEN   = 1;
  localparam int CFG_PULLEN = 2;
  localparam int CFG_DRVSTR = 3;

  typedef struct packed {
    logic             ok;
    logic             port;
    logic [BIT_W-1:0] bit_pos;
  } pin_map_t;

  // one entry of the per-pin store
  typedef struct packed {
    logic [3:0] cfg;
    logic [3:0] nibble;
  } cfg_entry_t;

endpackage
`default_nettype wire

/* design/pagp_pin_map.sv */
`timescale 1ns / 1ps
`default_nettype none
module pagp_pin_map (
  input  wire logic [7:0]         pin,
  output pagp_pkg::pin_map_t      map
);
  import pagp_pkg::*;

  logic [7:0] b;
  logic       hit;
  logic       port;

  // package pin to port and bit position
  always_comb begin
    hit  = 1'b1;
    port = PORT_A;
    b    = '0;
    if (pin >= 8'd1 && pin <= 8'd4) begin
      b = pin - 8'd1;
    end else if (pin >= 8'd7 && pin <= 8'd8) begin
      port = PORT_B;
      b    = pin + 8'd1;
    end else if (pin >= 8'd9 && pin <= 8'd16) begin
      b = pin - 8'd5;
    end else if (pin >= 8'd19 && pin <= 8'd20) begin
      port = PORT_B;
      b    = pin - 8'd9;
    end else if (pin >= 8'd21 && pin <= 8'd34) begin
      b = pin - 8'd9;
    end else if (pin >= 8'd37 && pin <= 8'd38) begin
      port = PORT_B;
      b    = pin - 8'd15;
    end else if (pin == 8'd39) begin
      b = pin - 8'd12;
    end else if (pin == 8'd41) begin
      b = pin - 8'd13;
    end else if (pin >= 8'd45 && pin <= 8'd46) begin
      b = pin - 8'd15;
    end else if (pin >= 8'd47 && pin <= 8'd48) begin
      port = PORT_B;
      b    = pin - 8'd45;
    end else begin
      hit = 1'b0;
    end
  end

  // bits beyond the port width count as unmapped
  always_comb begin
    map.ok      = hit && (int'(b) < BITS_PER_PORT);
    map.port    = port;
    map.bit_pos = b[BIT_W-1:0];
  end

endmodule
`default_nettype wire

/* design/pagp_cfg_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module pagp_cfg_mem (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       rd_en,
  input  wire logic [pagp_pkg::IDX_W-1:0] rd_addr,
  output pagp_pkg::cfg_entry_t            rd_data,
  input  wire logic                       wr_en,
  input  wire logic [pagp_pkg::IDX_W-1:0] wr_addr,
  input  wire pagp_pkg::cfg_entry_t       wr_data
);
  import pagp_pkg::*;

  cfg_entry_t           mem [CFG_DEPTH];
  logic [CFG_DEPTH-1:0] vld_r;
  cfg_entry_t           rd_q_r;
  logic                 rd_vld_r;

  // storage array, one write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r   <= mem[rd_addr];
      rd_vld_r <= vld_r[rd_addr];
    end
  end

  // entry valid bits, cleared at reset so unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '0;

endmodule
`default_nettype wire

/* design/pin_addressed_gpio_port.sv */
`timescale 1ns / 1ps
`default_nettype none
// result: the accepting edge sets busy_r, and busy_r in turn sets valid_r,
//   which drives the result strobe
// handshake: no new request is taken while busy, as the per-pin store read
//   is followed by its write-back
// reset: port latches, direction bits and store valid bits clear at once
// results cannot be stalled; out_valid is high for exactly one cycle
module pin_addressed_gpio_port (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  in_mode,
  input  wire logic [7:0]  in_pin,
  input  wire logic [3:0]  in_arg,
  input  wire logic [31:0] in_port_a_in,
  input  wire logic [31:0] in_port_b_in,
  output logic             out_valid,
  output logic             out_status,
  output logic             out_read_bit,
  output logic [31:0]      out_port_a_out,
  output logic [31:0]      out_port_b_out,
  output logic [31:0]      out_port_a_dir,
  output logic [31:0]      out_port_b_dir
);
  import pagp_pkg::*;

  logic             accept;
  pin_map_t         map;
  logic             busy_r;

  // captured request
  logic [2:0]       mode_r;
  logic [3:0]       value_r;
  pin_map_t         map_r;
  logic             pad_r;

  cfg_entry_t       rd_entry;
  cfg_entry_t       wr_entry;
  logic             wr_en;

  logic [31:0]      out_a_r, out_a_nxt, out_b_r, out_b_nxt;
  logic [31:0]      dir_a_r, dir_a_nxt, dir_b_r, dir_b_nxt;
  logic [31:0]      sel_out, sel_dir, new_out, new_dir, m;
  logic             fail, rd;

  logic             valid_r, status_r, read_bit_r;

  assign accept = start && !busy_r;

  pagp_pin_map u_map (
    .pin (in_pin),
    .map (map)
  );

  pagp_cfg_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr ({map.port, map.bit_pos}),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr ({map_r.port, map_r.bit_pos}),
    .wr_data (wr_entry)
  );

  // request capture, pad level sampled at accept
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r  <= in_mode;
      value_r <= in_arg;
      map_r   <= map;
      pad_r   <= (map.port == PORT_B) ? in_port_b_in[map.bit_pos]
                                      : in_port_a_in[map.bit_pos];
    end
  end

  // read-modify-write of the selected pin
  always_comb begin
    m        = 32'd1 << map_r.bit_pos;
    sel_out  = (map_r.port == PORT_B) ? out_b_r : out_a_r;
    sel_dir  = (map_r.port == PORT_B) ? dir_b_r : dir_a_r;
    new_out  = sel_out;
    new_dir  = sel_dir;
    wr_entry = rd_entry;
    wr_en    = 1'b0;
    fail     = 1'b1;
    rd       = 1'b0;
    if (map_r.ok) begin
      case (mode_r)
        MODE_MUX: begin
          if (value_r == MUX_DISABLE) begin
            wr_entry.cfg[CFG_MUXEN] = 1'b0;
            wr_en = 1'b1;
            fail  = 1'b0;
          end else if (value_r <= MUX_FN_MAX) begin
            wr_entry.nibble         = value_r;
            wr_entry.cfg[CFG_MUXEN] = 1'b1;
            wr_en = 1'b1;
            fail  = 1'b0;
          end
        end
        MODE_DIR: begin
          if (value_r == DIR_IN) begin
            new_dir = sel_dir & ~m;
            wr_entry.cfg[CFG_INEN] = 1'b1;
            wr_en = 1'b1;
            fail  = 1'b0;
          end else if (value_r == DIR_OUT) begin
            new_dir = sel_dir | m;
            fail    = 1'b0;
          end
        end
        MODE_WRITE: begin
          if (value_r == WR_LOW) begin
            new_out = sel_out & ~m;
            fail    = 1'b0;
          end else if (value_r == WR_HIGH) begin
            new_out = sel_out | m;
            fail    = 1'b0;
          end else if (value_r == WR_TOGGLE) begin
            new_out = sel_out ^ m;
            fail    = 1'b0;
          end
        end
        MODE_READ: begin
          rd   = pad_r;
          fail = 1'b0;
        end
        MODE_DRIVE: begin
          if (value_r <= FLAG_MAX) begin
            wr_entry.cfg[CFG_DRVSTR] = value_r[0];
            wr_en = 1'b1;
            fail  = 1'b0;
          end
        end
        MODE_PULL: begin
          if (value_r <= FLAG_MAX) begin
            wr_entry.cfg[CFG_PULLEN] = value_r[0];
            wr_en = 1'b1;
            fail  = 1'b0;
          end
        end
        default: begin
          fail = 1'b1;
        end
      endcase
    end
    wr_en = wr_en && busy_r;
  end

  // port register next values
  always_comb begin
    out_a_nxt = out_a_r;
    out_b_nxt = out_b_r;
    dir_a_nxt = dir_a_r;
    dir_b_nxt = dir_b_r;
    if (busy_r) begin
      if (map_r.port == PORT_B) begin
        out_b_nxt = new_out;
        dir_b_nxt = new_dir;
      end else begin
        out_a_nxt = new_out;
        dir_a_nxt = new_dir;
      end
    end
  end

  // control and port registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      out_a_r <= '0;
      out_b_r <= '0;
      dir_a_r <= '0;
      dir_b_r <= '0;
    end else begin
      busy_r  <= accept;
      valid_r <= busy_r;
      out_a_r <= out_a_nxt;
      out_b_r <= out_b_nxt;
      dir_a_r <= dir_a_nxt;
      dir_b_r <= dir_b_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (busy_r) begin
      status_r   <= fail;
      read_bit_r <= rd;
    end
  end

  assign busy           = busy_r;
  assign out_valid      = valid_r;
  assign out_status     = status_r;
  assign out_read_bit   = read_bit_r;
  assign out_port_a_out = out_a_r & PORT_MASK;
  assign out_port_b_out = out_b_r & PORT_MASK;
  assign out_port_a_dir = dir_a_r & PORT_MASK;
  assign out_port_b_dir = dir_b_r & PORT_MASK;

  // every accepted request sets busy and then gives exactly one strobe
  a_strobe_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r ##1 valid_r)
    else $error("result strobe missing after request");

  // strobe never overlaps the working cycle
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> !busy_r)
    else $error("strobe while busy");

  // a failed request leaves the port registers untouched
  a_fail_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && status_r) |->
      (out_a_r == $past(out_a_r) && out_b_r == $past(out_b_r) &&
       dir_a_r == $past(dir_a_r) && dir_b_r == $past(dir_b_r)))
    else $error("port state changed on failed request");

  // a pad level is only reported by a successful read
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && read_bit_r) |-> !status_r)
    else $error("read level reported with failure");

endmodule
`default_nettype wire
